@@ rtl/sha1sh_pkg.sv @@
// shared types, constants and codes for the sha-1 stream hasher
`default_nettype none

package sha1sh_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic {
		CMD_ABSORB = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		word_t       digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam int unsigned NUM_WORDS = 5;
	localparam int unsigned WIN_DEPTH = 16;

	localparam logic [6:0] LAST_ROUND   = 7'd79;
	localparam logic [6:0] SCHED_ROUNDS = 7'd16;
	localparam logic [6:0] PHASE1_END   = 7'd20;
	localparam logic [6:0] PHASE2_END   = 7'd40;
	localparam logic [6:0] PHASE3_END   = 7'd60;

	localparam logic [5:0] LAST_BYTE_POS = 6'd63;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [7:0] PAD_MARK      = 8'h80;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam word_t H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

endpackage

`default_nettype wire

@@ rtl/sha1sh_round.sv @@
// one sha-1 compression round: mixing function, round constant and five-term add
`default_nettype none

module sha1sh_round (
	input  sha1sh_pkg::word_t  a,
	input  sha1sh_pkg::word_t  b,
	input  sha1sh_pkg::word_t  c,
	input  sha1sh_pkg::word_t  d,
	input  sha1sh_pkg::word_t  e,
	input  sha1sh_pkg::word_t  w,
	input  logic [6:0]         round_idx,
	output sha1sh_pkg::word_t  t
);
	import sha1sh_pkg::*;

	word_t f;
	word_t k;

	always_comb begin
		priority if (round_idx < PHASE1_END) begin
			f = (b & c) | (~b & d);
			k = K0;
		end else if (round_idx < PHASE2_END) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (round_idx < PHASE3_END) begin
			f = (b & c) | (b & d) | (c & d);
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + w + k;

endmodule

`default_nettype wire

@@ rtl/sha1_stream_hasher_core.sv @@
// top level of the sha-1 stream hasher: byte packing, padding, schedule and round sequencer
`default_nettype none

// SHA-1 hasher fed one byte per input beat (cmd absorb) and closed by a finish beat,
// which answers with the five big-endian digest words on the output channel, the
// fifth marked last; the hasher then starts over for the next message. An absorb
// beat is taken while the input is ready; after every 64th byte of a message the
// input stays not ready while one shared round unit runs the 80 rounds one per
// cycle against a 16-word shift line for the schedule, then the fold step folds
// the result into the chaining words. A finish beat shifts in the 0x80 mark, zeros
// and the 8-byte length one byte per cycle through the same path, with one
// compression, or, with more than 55 bytes pending, two compressions. An emit step
// then loads the digest into the output register and the input is ready again.
// Digest words drain on their own; a following finish waits in that load step
// only if the previous digest is still being read out.
module sha1_stream_hasher_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  sha1sh_pkg::item_t    item,
	output logic                 digest_valid,
	input  logic                 digest_ready,
	output sha1sh_pkg::digest_t  digest
);
	import sha1sh_pkg::*;

	state_t      state_q, state_d;

	word_t       h_q [NUM_WORDS];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       win_q [WIN_DEPTH];
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic [6:0]  round_q;

	logic        finishing_q;
	logic        mark_done_q;
	logic [2:0]  len_cnt_q;
	logic        len_done_q;

	logic [159:0] dig_q;
	logic [2:0]   out_cnt_q;
	logic         out_valid_q;

	logic        in_fire;
	logic        out_fire;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        in_len;
	logic        emit;
	logic        win_shift;
	word_t       win_in;
	word_t       w_sched;
	word_t       t_round;
	logic [63:0] len_bits;

	assign item_ready = (state_q == ST_IDLE);
	assign in_fire    = item_valid && item_ready;
	assign out_fire   = out_valid_q && digest_ready;

	assign len_bits = {byte_cnt_q, 3'b000};
	assign in_len   = mark_done_q && ((len_cnt_q != 3'd0) || (fill_q == LEN_POS));

	// next state and byte source
	always_comb begin
		state_d   = state_q;
		push_en   = 1'b0;
		push_byte = item.data_byte;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (item.cmd == CMD_ABSORB) begin
						push_en = 1'b1;
						if (fill_q == LAST_BYTE_POS) begin
							state_d = ST_ROUND;
						end
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (!mark_done_q) begin
					push_byte = PAD_MARK;
				end else if (in_len) begin
					push_byte = len_bits[{~len_cnt_q, 3'b000} +: 8];
				end else begin
					push_byte = 8'h00;
				end
				if (fill_q == LAST_BYTE_POS) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (len_done_q) begin
					state_d = ST_EMIT;
				end else if (finishing_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// schedule word: stored words for the first sixteen rounds, then the expansion
	assign w_sched = (round_q < SCHED_ROUNDS) ? win_q[0] :
		{win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
		 win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

	assign win_shift = (push_en && (fill_q[1:0] == 2'b11)) || (state_q == ST_ROUND);
	assign win_in    = (state_q == ST_ROUND) ? w_sched : {acc_q, push_byte};

	sha1sh_round u_round (
		.a         (a_q),
		.b         (b_q),
		.c         (c_q),
		.d         (d_q),
		.e         (e_q),
		.w         (w_sched),
		.round_idx (round_q),
		.t         (t_round)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			round_q     <= '0;
			finishing_q <= 1'b0;
			mark_done_q <= 1'b0;
			len_cnt_q   <= '0;
			len_done_q  <= 1'b0;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && (item.cmd == CMD_ABSORB)) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end
			if (in_fire && (item.cmd == CMD_FINISH)) begin
				finishing_q <= 1'b1;
			end
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == LAST_BYTE_POS) begin
					round_q <= '0;
				end
			end
			if ((state_q == ST_PAD) && !mark_done_q) begin
				mark_done_q <= 1'b1;
			end
			if ((state_q == ST_PAD) && in_len) begin
				len_cnt_q <= len_cnt_q + 3'd1;
				if (len_cnt_q == LAST_LEN_BYTE) begin
					len_done_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == ST_FOLD) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (out_fire) begin
				out_cnt_q <= out_cnt_q + 3'd1;
				if (out_cnt_q == LAST_WORD_IDX) begin
					out_valid_q <= 1'b0;
				end
			end
			if (emit) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					h_q[i] <= H_INIT[i];
				end
				byte_cnt_q  <= '0;
				finishing_q <= 1'b0;
				mark_done_q <= 1'b0;
				len_cnt_q   <= '0;
				len_done_q  <= 1'b0;
				out_cnt_q   <= '0;
				out_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (fill_q == LAST_BYTE_POS) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end
		if (state_q == ST_ROUND) begin
			a_q <= t_round;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (win_shift) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WIN_DEPTH - 1] <= win_in;
		end
		if (emit) begin
			dig_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		end else if (out_fire) begin
			dig_q <= {dig_q[127:0], 32'h0000_0000};
		end
	end

	assign digest_valid       = out_valid_q;
	assign digest.digest_word = dig_q[159:128];
	assign digest.word_index  = out_cnt_q;
	assign digest.last_word   = (out_cnt_q == LAST_WORD_IDX);

endmodule

`default_nettype wire

@@ rtl/sha1sh_checker.sv @@
// port-level checks for the sha-1 stream hasher, bound to the top level
`default_nettype none

module sha1sh_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  sha1sh_pkg::item_t    item,
	input  logic                 digest_valid,
	input  logic                 digest_ready,
	input  sha1sh_pkg::digest_t  digest
);
	import sha1sh_pkg::*;

	// a stalled digest beat holds
	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest))
		else $error("digest beat changed while stalled");

	// words of one digest come back to back in index order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !digest.last_word
		|=> digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1))
		else $error("digest word out of order");

	// last flag only on the fifth word
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.last_word == (digest.word_index == LAST_WORD_IDX)))
		else $error("last_word does not match word_index");

	// a finish beat always starts padding, so input stalls next cycle
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.cmd == CMD_FINISH) |=> !item_ready)
		else $error("input ready right after finish");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.digest_valid (digest_valid),
	.digest_ready (digest_ready),
	.digest       (digest)
);

`default_nettype wire
